>>> sv/aebc_pkg.sv
// shared types and constants of the auto exposure brightness control block
`timescale 1ns / 1ps

package aebc_pkg;

    // framebuffer word layout
    localparam int WORD_W       = 64;
    localparam int PIX_W        = 16;
    localparam int PIX_PER_WORD = 4;
    localparam int CHAN_W       = 5;

    // one pixel level is 0..186, one word level 0..744
    localparam int LEVEL_W      = 8;
    localparam int LEVEL_MAX    = 186;
    localparam int WORD_LVL_MAX = 744;
    localparam int WORD_LVL_W   = 10;

    // exposure is unsigned q8.8
    localparam int EXP_W = 16;

    // sample set length default
    localparam int SAMPLE_WORDS_DEF = 32;

    // register widths
    localparam int THR_W   = 8;
    localparam int STEP_W  = 8;
    localparam int SOFT_W  = 16;
    localparam int DECAY_W = 10;

    // register reset values
    localparam logic [THR_W-1:0]   HIGH_THR_RST   = 8'd132;
    localparam logic [THR_W-1:0]   LOW_THR_RST    = 8'd76;
    localparam logic [STEP_W-1:0]  EXP_STEP_RST   = 8'd10;
    localparam logic [SOFT_W-1:0]  SOFT_LIMIT_RST = 16'd2560;
    localparam logic [DECAY_W-1:0] DECAY_STEP_RST = 10'd64;
    localparam logic [EXP_W-1:0]   EXPOSURE_RST   = 16'd7680;

    // register indexes of the write channel
    typedef enum logic [2:0] {
        CFG_HIGH_THR   = 3'd0,
        CFG_LOW_THR    = 3'd1,
        CFG_EXP_STEP   = 3'd2,
        CFG_SOFT_LIMIT = 3'd3,
        CFG_DECAY_STEP = 3'd4
    } t_cfg_idx;

    // control registers as seen by the update stage
    typedef struct packed {
        logic [THR_W-1:0]   high_thr;
        logic [THR_W-1:0]   low_thr;
        logic [STEP_W-1:0]  exp_step;
        logic [SOFT_W-1:0]  soft_limit;
        logic [DECAY_W-1:0] decay_step;
    } t_cfg;

endpackage

>>> sv/aebc_lane.sv
// one pixel lane: brightness level of an rgba5551 pixel
`timescale 1ns / 1ps

module aebc_lane (
    input  logic [aebc_pkg::PIX_W-1:0]   i_pixel,
    output logic [aebc_pkg::LEVEL_W-1:0] o_level
);

    logic [aebc_pkg::CHAN_W-1:0] red;
    logic [aebc_pkg::CHAN_W-1:0] green;
    logic [aebc_pkg::CHAN_W-1:0] blue;

    // channel fields, alpha bit dropped
    assign red   = i_pixel[15:11];
    assign green = i_pixel[10:6];
    assign blue  = i_pixel[5:1];

    // each channel counts twice its value
    assign o_level = {2'b00, red,   1'b0}
                   + {2'b00, green, 1'b0}
                   + {2'b00, blue,  1'b0};

endmodule

>>> sv/aebc_merge.sv
// merging stage: sums the lane levels of a word and accumulates a sample set
`timescale 1ns / 1ps

module aebc_merge #(
    parameter int SAMPLE_WORDS = aebc_pkg::SAMPLE_WORDS_DEF,
    parameter int SUM_W        = 15
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [aebc_pkg::LEVEL_W-1:0] i_lane_level [aebc_pkg::PIX_PER_WORD],
    input  logic                         i_valid,
    output logic                         o_ready,
    output logic                         o_total_valid,
    input  logic                         i_total_ready,
    output logic [SUM_W-1:0]             o_total
);

    localparam int CNT_W = $clog2(SAMPLE_WORDS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_WORDS - 1);

    logic [aebc_pkg::WORD_LVL_W-1:0] n_word_sum;
    logic [aebc_pkg::WORD_LVL_W-1:0] r_word_sum;
    logic                            r_word_valid;
    logic [SUM_W-1:0]                r_sum;
    logic [CNT_W-1:0]                r_count;
    logic [SUM_W-1:0]                r_total;
    logic                            r_total_valid;
    logic [SUM_W-1:0]                n_sum;
    logic                            word_last;
    logic                            word_fire;
    logic                            total_free;

    // adder tree over the lanes
    always_comb begin
        n_word_sum = (aebc_pkg::WORD_LVL_W'(i_lane_level[0])
                   + aebc_pkg::WORD_LVL_W'(i_lane_level[1]))
                   + (aebc_pkg::WORD_LVL_W'(i_lane_level[2])
                   + aebc_pkg::WORD_LVL_W'(i_lane_level[3]));
    end

    // a word that closes a set waits for room in the total register
    assign n_sum      = r_sum + SUM_W'(r_word_sum);
    assign word_last  = (r_count == CNT_LAST);
    assign total_free = !r_total_valid || i_total_ready;
    assign word_fire  = r_word_valid && (!word_last || total_free);
    assign o_ready    = !r_word_valid || word_fire;

    // handshake, count and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid  <= 1'b0;
            r_total_valid <= 1'b0;
            r_count       <= '0;
            r_sum         <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_word_valid <= 1'b1;
            end else if (word_fire) begin
                r_word_valid <= 1'b0;
            end

            if (word_fire) begin
                if (word_last) begin
                    r_count <= '0;
                    r_sum   <= '0;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                    r_sum   <= n_sum;
                end
            end

            if (word_fire && word_last) begin
                r_total_valid <= 1'b1;
            end else if (i_total_ready) begin
                r_total_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word_sum <= n_word_sum;
        end
        if (word_fire && word_last) begin
            r_total <= n_sum;
        end
    end

    assign o_total_valid = r_total_valid;
    assign o_total       = r_total;

endmodule

>>> sv/aebc_expo.sv
// average level by reciprocal multiply, exposure update and result register
`timescale 1ns / 1ps

module aebc_expo #(
    parameter int SAMPLE_WORDS = aebc_pkg::SAMPLE_WORDS_DEF,
    parameter int SUM_W        = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  aebc_pkg::t_cfg             i_cfg,
    input  logic                       i_total_valid,
    output logic                       o_total_ready,
    input  logic [SUM_W-1:0]           i_total,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [aebc_pkg::EXP_W-1:0] o_exposure,
    output logic [aebc_pkg::LEVEL_W-1:0] o_level
);

    // floor(total / divisor) == (total * recip) >> shift for any total below 2**SUM_W
    localparam longint unsigned DIVISOR = longint'(aebc_pkg::PIX_PER_WORD * SAMPLE_WORDS);
    localparam int              DIV_LOG = $clog2(aebc_pkg::PIX_PER_WORD * SAMPLE_WORDS);
    localparam int              SHIFT   = SUM_W + DIV_LOG;
    localparam int              RECIP_W = SUM_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR);
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int E_W    = aebc_pkg::EXP_W + 2;
    localparam logic signed [E_W-1:0] E_MAX = {2'b00, {aebc_pkg::EXP_W{1'b1}}};

    logic                          r_prod_valid;
    logic [PROD_W-1:0]             r_prod;
    logic                          r_out_valid;
    logic [aebc_pkg::EXP_W-1:0]    r_exposure;
    logic [aebc_pkg::LEVEL_W-1:0]  r_level;
    logic [aebc_pkg::EXP_W-1:0]    n_exposure;
    logic [PROD_W-1:0]             prod_shift;
    logic [aebc_pkg::LEVEL_W-1:0]  level;
    logic                          out_free;
    logic                          prod_fire;
    logic signed [E_W-1:0]         exp_cur;
    logic signed [E_W-1:0]         step;
    logic signed [E_W-1:0]         soft_lim;
    logic signed [E_W-1:0]         decay;
    logic signed [E_W-1:0]         e_step;
    logic signed [E_W-1:0]         e_decay;

    assign out_free      = !r_out_valid || i_ready;
    assign o_total_ready = !r_prod_valid || out_free;
    assign prod_fire     = r_prod_valid && out_free;

    // quotient bits of the product
    assign prod_shift = r_prod >> SHIFT;
    assign level      = prod_shift[aebc_pkg::LEVEL_W-1:0];

    // threshold step, soft limit decay, then clamp to the q8.8 range
    always_comb begin
        exp_cur  = signed'({2'b00, r_exposure});
        step     = signed'(E_W'(i_cfg.exp_step));
        soft_lim = signed'(E_W'(i_cfg.soft_limit));
        decay    = signed'(E_W'(i_cfg.decay_step));

        if (level > i_cfg.high_thr) begin
            e_step = exp_cur - step;
        end else if (level < i_cfg.low_thr) begin
            e_step = exp_cur + step;
        end else begin
            e_step = exp_cur;
        end

        if (e_step > soft_lim) begin
            e_decay = e_step - decay;
        end else begin
            e_decay = e_step;
        end

        if (e_decay < 0) begin
            n_exposure = '0;
        end else if (e_decay > E_MAX) begin
            n_exposure = '1;
        end else begin
            n_exposure = e_decay[aebc_pkg::EXP_W-1:0];
        end
    end

    // stage valids and exposure state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_exposure   <= aebc_pkg::EXPOSURE_RST;
        end else begin
            if (i_total_valid && o_total_ready) begin
                r_prod_valid <= 1'b1;
            end else if (out_free) begin
                r_prod_valid <= 1'b0;
            end

            if (prod_fire) begin
                r_out_valid <= 1'b1;
                r_exposure  <= n_exposure;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_total_valid && o_total_ready) begin
            r_prod <= PROD_W'(i_total) * PROD_W'(RECIP);
        end
        if (prod_fire) begin
            r_level <= level;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_exposure = r_exposure;
    assign o_level    = r_level;

endmodule

>>> sv/auto_exposure_brightness_control.sv
// top level of the auto exposure brightness control block
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  s_axis_tdata[63:0] sample_word
//   m_axis    out        m_axis_tvalid / m_axis_tready  m_axis_tdata[23:0] exposure, level
//   cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// one word per cycle unless a word that closes a set is stalled; four pixel lanes and a word adder feed an accumulator
// a result follows each word that closes a sample set, registered through the stages below
// stages: word sum, set total, reciprocal multiply, exposure update into the result register
// a stalled result holds only words that close a set; others keep flowing
// synchronous active-low reset clears handshake state, counters and loads reset exposure
`timescale 1ns / 1ps

module auto_exposure_brightness_control #(
    parameter int SAMPLE_WORDS = aebc_pkg::SAMPLE_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] sample_word
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] exposure_value, [23:16] average_level
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SUM_W = $clog2(aebc_pkg::WORD_LVL_MAX * SAMPLE_WORDS + 1);

    aebc_pkg::t_cfg               r_cfg;
    logic [aebc_pkg::LEVEL_W-1:0] lane_level [aebc_pkg::PIX_PER_WORD];
    logic                         total_valid;
    logic                         total_ready;
    logic [SUM_W-1:0]             total;
    logic [aebc_pkg::EXP_W-1:0]   exposure;
    logic [aebc_pkg::LEVEL_W-1:0] level;

    // register writes, masked to width
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_thr   <= aebc_pkg::HIGH_THR_RST;
            r_cfg.low_thr    <= aebc_pkg::LOW_THR_RST;
            r_cfg.exp_step   <= aebc_pkg::EXP_STEP_RST;
            r_cfg.soft_limit <= aebc_pkg::SOFT_LIMIT_RST;
            r_cfg.decay_step <= aebc_pkg::DECAY_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (aebc_pkg::t_cfg_idx'(i_cfg_index))
                aebc_pkg::CFG_HIGH_THR:   r_cfg.high_thr   <= i_cfg_data[aebc_pkg::THR_W-1:0];
                aebc_pkg::CFG_LOW_THR:    r_cfg.low_thr    <= i_cfg_data[aebc_pkg::THR_W-1:0];
                aebc_pkg::CFG_EXP_STEP:   r_cfg.exp_step   <= i_cfg_data[aebc_pkg::STEP_W-1:0];
                aebc_pkg::CFG_SOFT_LIMIT: r_cfg.soft_limit <= i_cfg_data[aebc_pkg::SOFT_W-1:0];
                aebc_pkg::CFG_DECAY_STEP: r_cfg.decay_step <= i_cfg_data[aebc_pkg::DECAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pixel lanes
    for (genvar k = 0; k < aebc_pkg::PIX_PER_WORD; k++) begin : g_lane
        aebc_lane u_lane (
            .i_pixel (s_axis_tdata[k*aebc_pkg::PIX_W +: aebc_pkg::PIX_W]),
            .o_level (lane_level[k])
        );
    end

    // word sum and set accumulation
    aebc_merge #(
        .SAMPLE_WORDS (SAMPLE_WORDS),
        .SUM_W        (SUM_W)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_lane_level  (lane_level),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .o_total_valid (total_valid),
        .i_total_ready (total_ready),
        .o_total       (total)
    );

    // average level and exposure update
    aebc_expo #(
        .SAMPLE_WORDS (SAMPLE_WORDS),
        .SUM_W        (SUM_W)
    ) u_expo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_total_valid (total_valid),
        .o_total_ready (total_ready),
        .i_total       (total),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_exposure    (exposure),
        .o_level       (level)
    );

    assign m_axis_tdata = {level, exposure};

`ifndef SYNTHESIS
    // the average of pixel levels never exceeds one pixel's maximum
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:16] <= aebc_pkg::LEVEL_W'(aebc_pkg::LEVEL_MAX)))
        else $error("average level above pixel maximum");

    // the input side stalls only when a result is held back downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    // a result appears only after a completed sample set total was presented to the update stage
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(total_valid, 2))
        else $error("result without a completed sample set");
`endif

endmodule
